/* rtl/core/ihc_pkg.sv */
// shared types and constants for the ipv4 / hostname classifier
package ihc_pkg;

   localparam int CHAR_WIDTH = 16;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 16'h0030;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE   = 16'h0039;
   localparam logic [CHAR_WIDTH-1:0] CHAR_DOT    = 16'h002E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_HYPHEN = 16'h002D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UC_A   = 16'h0041;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UC_Z   = 16'h005A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LC_A   = 16'h0061;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LC_Z   = 16'h007A;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MAX   = 16'h007F;

   localparam int QUAD_MAX_LENGTH = 15;
   localparam logic [9:0] QUAD_PART_MAX = 10'd255;
   localparam logic [2:0] QUAD_PARTS = 3'd4;
   localparam logic [2:0] QUAD_PARTS_SAT = 3'd5;
   localparam logic [2:0] PART_DIGITS_MAX = 3'd3;
   localparam logic [2:0] PART_DIGITS_SAT = 3'd4;

   typedef enum logic [1:0] {
      CLASS_INVALID = 2'd0,
      CLASS_IPV4    = 2'd1,
      CLASS_DOMAIN  = 2'd2
   } ihc_class_type;

   // one character word presented to the scanner
   typedef struct packed {
      logic                  step;
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  is_final;
   } ihc_step_type;

endpackage

/* rtl/core/ihc_if.sv */
// request and response channel interfaces of the classifier
interface ihc_req_if import ihc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_code;
   logic                  is_final;

   modport source (output valid, output char_code, output is_final, input ready);
   modport sink (input valid, input char_code, input is_final, output ready);
endinterface

interface ihc_rsp_if ();
   logic       valid;
   logic       ready;
   logic [1:0] address_class;

   modport source (output valid, output address_class, input ready);
   modport sink (input valid, input address_class, output ready);
endinterface

/* rtl/core/ipv4_or_hostname_classifier_unit.sv */
// top level of the ipv4 dotted quad / domain name classifier
// Takes one character word per clock, except where a final word stalls (see below):
// each character is held in the input register while the scan state
// (lengths, current part, current label) is updated from it, and
// the final character of a string loads the verdict into the output register,
// so a result reaches rsp_ch through the input and then the output register. While
// a result waits on rsp_ch the block still takes characters; only a second final
// word stalls until the waiting result is taken. One result per string:
// 0 invalid, 1 IPv4 dotted quad (wins when both formats match), 2 domain name.
module ipv4_or_hostname_classifier_unit import ihc_pkg::*; #(
   parameter int MAX_NAME_LENGTH  = 253,
   parameter int MAX_LABEL_LENGTH = 63
) (
   input  logic      clock,
   input  logic      reset,
   ihc_req_if.sink   req_ch,
   ihc_rsp_if.source rsp_ch
);

   logic                  in_valid_ff;
   logic [CHAR_WIDTH-1:0] in_char_ff;
   logic                  in_final_ff;
   logic                  out_valid_ff;
   ihc_class_type         out_class_ff;
   logic                  out_free;
   logic                  consume;
   ihc_step_type          step;
   ihc_class_type         verdict;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign consume  = in_valid_ff && (!in_final_ff || out_free);
   assign req_ch.ready = !in_valid_ff || consume;

   assign step = '{step: consume, char_code: in_char_ff, is_final: in_final_ff};

   ihc_scan #(
      .MAX_NAME_LENGTH  (MAX_NAME_LENGTH),
      .MAX_LABEL_LENGTH (MAX_LABEL_LENGTH)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .step_in       (step),
      .address_class (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_char_ff  <= req_ch.char_code;
         in_final_ff <= req_ch.is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (consume && in_final_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && in_final_ff) out_class_ff <= verdict;
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.address_class = out_class_ff;

endmodule

/* rtl/core/ihc_scan.sv */
// per-string scan state and its combinational update for both format checks
module ihc_scan import ihc_pkg::*; #(
   parameter int MAX_NAME_LENGTH  = 253,
   parameter int MAX_LABEL_LENGTH = 63
) (
   input  logic          clock,
   input  logic          reset,
   input  ihc_step_type  step_in,
   output ihc_class_type address_class
);

   localparam int TLW = $clog2(MAX_NAME_LENGTH + 2);
   localparam int LLW = $clog2(MAX_LABEL_LENGTH + 1);
   localparam logic [TLW-1:0] TOTAL_SAT  = TLW'(MAX_NAME_LENGTH + 1);
   localparam logic [TLW-1:0] TOTAL_MAX  = TLW'(MAX_NAME_LENGTH);
   localparam logic [TLW-1:0] QUAD_LIMIT = TLW'(QUAD_MAX_LENGTH);
   localparam logic [LLW-1:0] LABEL_MAX  = LLW'(MAX_LABEL_LENGTH);

   typedef struct packed {
      logic       valid;
      logic [2:0] digits;
      logic [9:0] value;
      logic       lead_zero;
      logic [2:0] parts;
   } quad_type;

   typedef struct packed {
      logic           valid;
      logic [LLW-1:0] label_len;
      logic           prev_hyphen;
      logic           seen_dot;
   } name_type;

   localparam quad_type QUAD_RESET = '{valid: 1'b1, digits: 3'd0, value: 10'd0,
                                       lead_zero: 1'b0, parts: 3'd0};
   localparam name_type NAME_RESET = '{valid: 1'b1, label_len: '0, prev_hyphen: 1'b0,
                                       seen_dot: 1'b0};

   logic [TLW-1:0] total_ff, total_in;
   quad_type       quad_ff, quad_in;
   name_type       name_ff, name_in;

   function automatic quad_type close_part(input quad_type q);
      quad_type r;
      r = q;
      if (q.digits == 3'd0 || q.digits > PART_DIGITS_MAX) r.valid = 1'b0;
      if (q.value > QUAD_PART_MAX) r.valid = 1'b0;
      if (q.parts < QUAD_PARTS_SAT) r.parts = q.parts + 3'd1;
      r.digits    = 3'd0;
      r.value     = 10'd0;
      r.lead_zero = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic [CHAR_WIDTH-1:0] c;
      logic                  is_digit;
      logic                  is_letter;
      logic                  grow;
      c = step_in.char_code;
      is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_letter = ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ||
                  ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z));
      grow = 1'b0;

      total_in = total_ff;
      quad_in  = quad_ff;
      name_in  = name_ff;
      address_class = CLASS_INVALID;

      if (total_ff < TOTAL_SAT) total_in = total_ff + TLW'(1);

      if (c > ASCII_MAX) begin
         quad_in.valid = 1'b0;
         name_in.valid = 1'b0;
      end

      // dotted quad
      if (is_digit) begin
         if (quad_ff.digits == 3'd0) begin
            quad_in.lead_zero = (c == CHAR_ZERO);
         end else if (quad_ff.lead_zero) begin
            quad_in.valid = 1'b0;
         end
         if (quad_ff.digits < PART_DIGITS_MAX) begin
            quad_in.value = {quad_ff.value[6:0], 3'b000} + {quad_ff.value[8:0], 1'b0}
                            + {6'd0, c[3:0]};
         end
         if (quad_ff.digits < PART_DIGITS_SAT) quad_in.digits = quad_ff.digits + 3'd1;
         if (quad_in.digits > PART_DIGITS_MAX) quad_in.valid = 1'b0;
      end else if (c == CHAR_DOT) begin
         quad_in = close_part(quad_in);
      end else begin
         quad_in.valid = 1'b0;
      end

      // domain name
      if (is_digit || is_letter) begin
         grow = 1'b1;
         name_in.prev_hyphen = 1'b0;
      end else if (c == CHAR_HYPHEN) begin
         if (name_ff.label_len == '0) name_in.valid = 1'b0;
         grow = 1'b1;
         name_in.prev_hyphen = 1'b1;
      end else if (c == CHAR_DOT) begin
         if (name_ff.label_len == '0 || name_ff.prev_hyphen) name_in.valid = 1'b0;
         name_in.seen_dot    = 1'b1;
         name_in.label_len   = '0;
         name_in.prev_hyphen = 1'b0;
      end else begin
         name_in.valid = 1'b0;
      end
      if (grow) begin
         if (name_ff.label_len >= LABEL_MAX) name_in.valid = 1'b0;
         else name_in.label_len = name_ff.label_len + LLW'(1);
      end

      // end of string: verdict, then back to the fresh state
      if (step_in.is_final) begin
         quad_in = close_part(quad_in);
         if (quad_in.parts != QUAD_PARTS || total_in > QUAD_LIMIT) quad_in.valid = 1'b0;
         if (name_in.label_len == '0 || name_in.prev_hyphen || !name_in.seen_dot ||
             total_in > TOTAL_MAX) name_in.valid = 1'b0;
         priority if (quad_in.valid) address_class = CLASS_IPV4;
         else if (name_in.valid) address_class = CLASS_DOMAIN;
         else address_class = CLASS_INVALID;
         total_in = '0;
         quad_in  = QUAD_RESET;
         name_in  = NAME_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         quad_ff  <= QUAD_RESET;
         name_ff  <= NAME_RESET;
      end else if (step_in.step) begin
         total_ff <= total_in;
         quad_ff  <= quad_in;
         name_ff  <= name_in;
      end
   end

endmodule

/* rtl/core/ihc_classifier_checker.sv */
// port-level checks of the classifier, bound to the top level
module ihc_classifier_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_class
);

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_class))
      else $error("stalled result word changed");

   // with the output side free the input side never stalls
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled while output side was free");

   a_quiet_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind ipv4_or_hostname_classifier_unit ihc_classifier_checker u_ihc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_class (rsp_ch.address_class)
);

/* dv/ihc_class_checker.sv */
// checker that predicts the classifier verdict of every string and compares results
`timescale 1ns / 100ps

module ihc_class_checker import ihc_pkg::*; #(
   parameter int NAME_LIMIT  = 253,
   parameter int LABEL_LIMIT = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CHAR_WIDTH-1:0] req_char_code,
   input  logic                  req_is_final,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [1:0]            rsp_address_class,
   output int                    error_count,
   output int                    open_count,
   output int                    invalid_count,
   output int                    quad_count,
   output int                    name_count
);

   // scan state of the string in flight
   logic [8:0] char_count;
   logic       quad_ok;
   logic [2:0] digit_count;
   logic [9:0] part_val;
   logic       lead_zero;
   logic [2:0] parts_done;
   logic       name_ok;
   logic [6:0] label_len;
   logic       last_hyphen;
   logic       dot_seen;

   ihc_class_type verdicts_due[$];
   int            strings_checked;

   task automatic clear_scan();
      char_count  = '0;
      quad_ok     = 1'b1;
      digit_count = '0;
      part_val    = '0;
      lead_zero   = 1'b0;
      parts_done  = '0;
      name_ok     = 1'b1;
      label_len   = '0;
      last_hyphen = 1'b0;
      dot_seen    = 1'b0;
   endtask

   // a dot or the end of the string closes the current dotted-quad part
   task automatic close_part();
      if (digit_count == 0 || digit_count > PART_DIGITS_MAX) quad_ok = 1'b0;
      if (part_val > QUAD_PART_MAX) quad_ok = 1'b0;
      if (parts_done < QUAD_PARTS_SAT) parts_done++;
      digit_count = '0;
      part_val    = '0;
      lead_zero   = 1'b0;
   endtask

   task automatic extend_label();
      if (label_len >= LABEL_LIMIT) name_ok = 1'b0;
      else label_len++;
   endtask

   task automatic classify_char(input logic [CHAR_WIDTH-1:0] code, input logic fin,
                                output logic emit, output ihc_class_type verdict);
      logic digit;
      logic letter;
      digit  = (code >= CHAR_ZERO) && (code <= CHAR_NINE);
      letter = ((code >= CHAR_LC_A) && (code <= CHAR_LC_Z)) ||
               ((code >= CHAR_UC_A) && (code <= CHAR_UC_Z));
      emit    = 1'b0;
      verdict = CLASS_INVALID;

      if (char_count < NAME_LIMIT + 1) char_count++;
      if (code > ASCII_MAX) begin
         quad_ok = 1'b0;
         name_ok = 1'b0;
      end

      if (digit) begin
         if (digit_count == 0) begin
            lead_zero = (code == CHAR_ZERO);
         end else if (lead_zero) begin
            quad_ok = 1'b0;
         end
         // only the first three digits feed the part value
         if (digit_count < PART_DIGITS_MAX)
            part_val = 10'(part_val * 10 + (code - CHAR_ZERO));
         if (digit_count < PART_DIGITS_SAT) digit_count++;
         if (digit_count > PART_DIGITS_MAX) quad_ok = 1'b0;
      end else if (code == CHAR_DOT) begin
         close_part();
      end else begin
         quad_ok = 1'b0;
      end

      if (digit || letter) begin
         extend_label();
         last_hyphen = 1'b0;
      end else if (code == CHAR_HYPHEN) begin
         if (label_len == 0) name_ok = 1'b0;
         extend_label();
         last_hyphen = 1'b1;
      end else if (code == CHAR_DOT) begin
         if (label_len == 0 || last_hyphen) name_ok = 1'b0;
         dot_seen    = 1'b1;
         label_len   = '0;
         last_hyphen = 1'b0;
      end else begin
         name_ok = 1'b0;
      end

      if (fin) begin
         close_part();
         if (parts_done != QUAD_PARTS || char_count > QUAD_MAX_LENGTH) quad_ok = 1'b0;
         if (label_len == 0 || last_hyphen || !dot_seen || char_count > NAME_LIMIT)
            name_ok = 1'b0;
         emit = 1'b1;
         if (quad_ok) verdict = CLASS_IPV4;
         else if (name_ok) verdict = CLASS_DOMAIN;
         else verdict = CLASS_INVALID;
         clear_scan();
      end
   endtask

   task automatic flag_mismatch(input string what);
      $display("%0t ns: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin : watch
      ihc_class_type due;
      ihc_class_type verdict;
      logic          emit;
      if (reset) begin
         clear_scan();
         verdicts_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               flag_mismatch($sformatf("verdict %0d with no string pending",
                                       rsp_address_class));
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_address_class !== due)
                  flag_mismatch($sformatf("string %0d: verdict %0d, expected %0d",
                                          strings_checked, rsp_address_class, due));
               case (due)
                  CLASS_IPV4:   quad_count++;
                  CLASS_DOMAIN: name_count++;
                  default:      invalid_count++;
               endcase
               strings_checked++;
            end
         end
         if (req_valid && req_ready) begin
            classify_char(req_char_code, req_is_final, emit, verdict);
            if (emit) verdicts_due = {verdicts_due, verdict};
         end
      end
      open_count = verdicts_due.size();
   end

endmodule

/* dv/ipv4_or_hostname_classifier_unit_test.sv */
// testbench top: drives character strings into the classifier and gives the verdict
`timescale 1ns / 100ps

module ipv4_or_hostname_classifier_unit_test import ihc_pkg::*;;

   localparam int NAME_LIMIT  = 253;
   localparam int LABEL_LIMIT = 63;
   localparam int HOLD_CYCLES = 400;

   logic clock;
   logic reset;

   ihc_req_if req_ch ();
   ihc_rsp_if rsp_ch ();

   int error_count;
   int open_count;
   int invalid_count;
   int quad_count;
   int name_count;

   logic [CHAR_WIDTH-1:0] text_q[$];
   bit                    gaps_on;
   bit                    stalls_on;
   int                    long_hold;
   int                    chars_sent;
   int                    strings_sent;

   ipv4_or_hostname_classifier_unit #(
      .MAX_NAME_LENGTH (NAME_LIMIT),
      .MAX_LABEL_LENGTH(LABEL_LIMIT)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   ihc_class_checker #(
      .NAME_LIMIT (NAME_LIMIT),
      .LABEL_LIMIT(LABEL_LIMIT)
   ) class_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_char_code    (req_ch.char_code),
      .req_is_final     (req_ch.is_final),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_address_class(rsp_ch.address_class),
      .error_count      (error_count),
      .open_count       (open_count),
      .invalid_count    (invalid_count),
      .quad_count       (quad_count),
      .name_count       (name_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #1000000;
      $display("ipv4_or_hostname_classifier_unit_test: errors");
      $finish;
   end

   // result side: random stalls, plus one long hold requested by the stimulus
   initial begin : result_side
      int n;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (long_hold - 1) @(negedge clock);
            long_hold = 0;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // append one character to the string being built
   task automatic add_char(input logic [CHAR_WIDTH-1:0] code);
      text_q = {text_q, code};
   endtask

   function automatic logic [CHAR_WIDTH-1:0] name_char();
      case ($urandom_range(0, 2))
         0:       return CHAR_WIDTH'(CHAR_LC_A + $urandom_range(0, 25));
         1:       return CHAR_WIDTH'(CHAR_UC_A + $urandom_range(0, 25));
         default: return CHAR_WIDTH'(CHAR_ZERO + $urandom_range(0, 9));
      endcase
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] odd_char();
      case ($urandom_range(0, 6))
         0:       return CHAR_DOT;
         1:       return CHAR_HYPHEN;
         2:       return CHAR_WIDTH'($urandom_range(0, ASCII_MAX));
         3:       return CHAR_WIDTH'($urandom_range(ASCII_MAX + 1, 16'hFFFF));
         4:       return CHAR_WIDTH'($urandom_range(0, 16'hFFFF));
         5:       return CHAR_ZERO;
         default: return name_char();
      endcase
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) add_char({8'h00, s[i]});
   endtask

   task automatic put_number(input int v);
      logic [CHAR_WIDTH-1:0] digs[$];
      do begin
         digs.push_front(CHAR_WIDTH'(CHAR_ZERO + v % 10));
         v = v / 10;
      end while (v > 0);
      foreach (digs[i]) add_char(digs[i]);
   endtask

   // hyphens only inside the label, never at its ends
   task automatic put_label(input int len);
      for (int i = 0; i < len; i++) begin
         if (i > 0 && i < len - 1 && $urandom_range(0, 4) == 0) add_char(CHAR_HYPHEN);
         else add_char(name_char());
      end
   endtask

   task automatic mutate();
      int idx;
      idx = $urandom_range(0, text_q.size() - 1);
      if ($urandom_range(0, 1) == 0) text_q[idx] = odd_char();
      else text_q.insert(idx, odd_char());
   endtask

   task automatic make_quad();
      int parts;
      bit broken;
      broken = ($urandom_range(0, 2) == 0);
      parts  = (broken && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6)
                                                      : int'(QUAD_PARTS);
      for (int i = 0; i < parts; i++) begin
         if (i > 0) add_char(CHAR_DOT);
         case (broken ? $urandom_range(0, 7) : 7)
            0: ; // empty part
            1: begin
               add_char(CHAR_ZERO);
               put_number($urandom_range(0, 99));
            end
            2: put_number($urandom_range(256, 999));
            3: put_number($urandom_range(1000, 9999));
            default: begin
               case ($urandom_range(0, 3))
                  0:       put_number(0);
                  1:       put_number(int'(QUAD_PART_MAX));
                  default: put_number($urandom_range(0, QUAD_PART_MAX));
               endcase
            end
         endcase
      end
   endtask

   task automatic make_name();
      int labels;
      bit broken;
      labels = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 4);
      broken = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < labels; i++) begin
         if (i > 0) add_char(CHAR_DOT);
         case (broken ? $urandom_range(0, 5) : 5)
            0: ; // empty label
            1: begin
               add_char(CHAR_HYPHEN);
               put_label($urandom_range(1, 6));
            end
            2: begin
               put_label($urandom_range(1, 6));
               add_char(CHAR_HYPHEN);
            end
            3: put_label(LABEL_LIMIT + $urandom_range(0, 1));
            4: begin
               put_label($urandom_range(1, 6));
               add_char(odd_char());
            end
            default: put_label($urandom_range(1, 8));
         endcase
      end
   endtask

   // labels of full size where the length allows, the last one filling up to the requested length
   task automatic make_long_name(input int total);
      int rem;
      int n;
      rem = total;
      while (rem > 0) begin
         if (rem <= LABEL_LIMIT) begin
            put_label(rem);
            rem = 0;
         end else begin
            n = (rem - 2 < LABEL_LIMIT) ? rem - 2 : LABEL_LIMIT;
            put_label(n);
            add_char(CHAR_DOT);
            rem -= n + 1;
         end
      end
   endtask

   task automatic make_random_string();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         make_quad();
      end else if (pick < 80) begin
         make_name();
      end else begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) == 0) add_char(odd_char());
            else add_char(name_char());
         end
      end
      if (text_q.size() > 0 && $urandom_range(0, 7) == 0) mutate();
   endtask

   task automatic send_char(input logic [CHAR_WIDTH-1:0] code, input logic fin);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= code;
      req_ch.is_final  <= fin;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      if (text_q.size() == 0) add_char(CHAR_LC_A);
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
      strings_sent++;
      text_q.delete();
   endtask

   // stop offering words until every pending verdict has come back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (open_count != 0);
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      req_ch.is_final  = 1'b0;
      gaps_on          = 1'b1;
      stalls_on        = 1'b1;
      long_hold        = 0;
      do @(negedge clock); while (reset);

      // short directed strings: formats, single characters, code extremes
      put_text("0.0.0.0");
      send_text();
      put_text("a-9.Z");
      send_text();
      put_text("x");
      send_text();
      add_char(16'h0000);
      send_text();
      add_char(ASCII_MAX);
      send_text();
      add_char(CHAR_WIDTH'(ASCII_MAX + 1));
      send_text();
      add_char(16'hFFFF);
      send_text();
      put_text("1.2");
      send_text();
      put_text("09.z");
      send_text();

      while (chars_sent < 700) begin
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         make_random_string();
         send_text();
      end

      // result side held off while strings keep coming, so the input backs up
      gaps_on   = 1'b0;
      long_hold = HOLD_CYCLES;
      repeat (12) begin
         make_random_string();
         send_text();
      end
      drain_results();

      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      make_long_name(NAME_LIMIT);
      send_text();
      make_long_name(NAME_LIMIT + 1);
      send_text();
      make_long_name(NAME_LIMIT + 4);
      send_text();
      put_label(LABEL_LIMIT);
      add_char(CHAR_DOT);
      put_label(LABEL_LIMIT);
      send_text();
      put_label(3);
      add_char(CHAR_DOT);
      put_label(LABEL_LIMIT + 1);
      send_text();
      put_text("255.255.255.255");
      send_text();

      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      while (chars_sent < 1800) begin
         make_random_string();
         send_text();
      end

      drain_results();
      repeat (8) @(negedge clock);

      $display("sent %0d characters in %0d strings, with gaps, stalls and a %0d-cycle hold",
               chars_sent, strings_sent, HOLD_CYCLES);
      $display("verdicts: %0d invalid, %0d ipv4, %0d domain; %0d mismatches",
               invalid_count, quad_count, name_count, error_count);
      if (error_count == 0) begin
         $display("ipv4_or_hostname_classifier_unit_test: clean");
      end else begin
         $display("ipv4_or_hostname_classifier_unit_test: errors");
      end
      $finish;
   end

endmodule
